// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // field widths at the ports
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned OIDX_W = 6;
  localparam int unsigned OCC_W  = 7;

  localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd6;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_SHIFT,
    CELL_MATCH
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/spq_in_if.sv -----
interface spq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] item_key;
  logic [15:0] item_tag;
  logic [5:0]  position;

  modport source (output valid, func, item_key, item_tag, position, input ready);
  modport sink   (input valid, func, item_key, item_tag, position, output ready);
endinterface

// ----- rtl/core/spq_out_if.sv -----
interface spq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_key;
  logic [15:0] out_tag;
  logic [5:0]  out_index;
  logic [2:0]  status;
  logic [6:0]  occupancy;

  modport source (output valid, out_key, out_tag, out_index, status, occupancy,
                  input ready);
  modport sink   (input valid, out_key, out_tag, out_index, status, occupancy,
                  output ready);
endinterface

// ----- rtl/core/spq_cell.sv -----
module spq_cell import spq_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             valid_i,
  input  logic             prev_gt_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic [TAG_W-1:0] left_tag_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic [TAG_W-1:0] right_tag_i,
  input  logic             shift_i,
  output logic [KEY_W-1:0] key_o,
  output logic [TAG_W-1:0] tag_o,
  output logic             gt_o,
  output logic             match_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic             match_q, match_d;

  // new key belongs behind this entry
  assign gt_o = valid_i && (ctrl_i.key > key_q);

  always_comb begin
    key_d   = key_q;
    tag_d   = tag_q;
    match_d = match_q;
    case (ctrl_i.op)
      CELL_PUSH: begin
        if (!gt_o) begin
          if (prev_gt_i) begin
            key_d = ctrl_i.key;
            tag_d = ctrl_i.tag;
          end else begin
            key_d = left_key_i;
            tag_d = left_tag_i;
          end
        end
      end
      CELL_SHIFT: begin
        if (shift_i) begin
          key_d = right_key_i;
          tag_d = right_tag_i;
        end
      end
      CELL_MATCH: match_d = valid_i && (tag_q == ctrl_i.tag);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    tag_q   <= tag_d;
    match_q <= match_d;
  end

  assign key_o   = key_q;
  assign tag_o   = tag_q;
  assign match_o = match_q;

endmodule

// ----- rtl/core/sorted_priority_queue_top.sv -----
// Channel | Dir | Fields                                          | Handshake
// in_i    | in  | func, item_key, item_tag, position              | valid/ready
// out_o   | out | out_key, out_tag, out_index, status, occupancy  | valid/ready
//
// Push, pop, peek, read, clear and unused codes finish straight from idle; find and
// remove go through a match state (every cell first compares its tag, then the
// first hit is encoded and the gap closed). No new item is taken during a match.
// Reset clears the entry count and the handshake state; cell contents are
// left as they are and never read past the count.
// A result waits in the output register; the next item is taken in the same
// cycle the waiting result leaves.
module sorted_priority_queue_top import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MATCH = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rm_q, rm_d;

  logic             out_valid_q, out_valid_d;
  logic [KEY_W-1:0] out_key_q, out_key_d;
  logic [TAG_W-1:0] out_tag_q, out_tag_d;
  logic [OIDX_W-1:0] out_idx_q, out_idx_d;
  status_e          out_stat_q, out_stat_d;
  logic [OCC_W-1:0] out_occ_q;
  logic             load;

  logic             accept;
  cell_ctrl_t       ctrl;
  logic [DEPTH-1:0] shift_vec;

  // row of cells
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [TAG_W-1:0] cell_tag [DEPTH];
  logic [DEPTH-1:0] cell_gt;
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] cell_valid;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic [TAG_W-1:0] lt, rt;
    logic             pg;
    if (g == 0) begin : g_first
      assign lk = '0;
      assign lt = '0;
      assign pg = 1'b1;
    end else begin : g_mid
      assign lk = cell_key[g-1];
      assign lt = cell_tag[g-1];
      assign pg = cell_gt[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rt = '0;
    end else begin : g_inner
      assign rk = cell_key[g+1];
      assign rt = cell_tag[g+1];
    end
    assign cell_valid[g] = (32'(g) < 32'(count_q));

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (cell_valid[g]),
      .prev_gt_i   (pg),
      .left_key_i  (lk),
      .left_tag_i  (lt),
      .right_key_i (rk),
      .right_tag_i (rt),
      .shift_i     (shift_vec[g]),
      .key_o       (cell_key[g]),
      .tag_o       (cell_tag[g]),
      .gt_o        (cell_gt[g]),
      .match_o     (cell_match[g])
    );
  end

  // first hit: prefix-OR in log steps, then one-hot of the lowest set bit
  logic [DEPTH-1:0]  hit_pre;
  logic [DEPTH-1:0]  hit_one;
  logic              hit_any;
  logic [OIDX_W-1:0] hit_idx;
  logic [KEY_W-1:0]  hit_key;
  logic [TAG_W-1:0]  hit_tag;

  always_comb begin
    hit_pre = cell_match;
    for (int s = 0; s < int'(IDX_W); s++) begin
      hit_pre = hit_pre | (hit_pre << (1 << s));
    end
    hit_one = hit_pre & ~(hit_pre << 1);
    hit_any = hit_pre[DEPTH-1];
    hit_idx = '0;
    hit_key = '0;
    hit_tag = '0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      if (hit_one[i]) begin
        hit_idx = hit_idx | OIDX_W'(i);
        hit_key = hit_key | cell_key[i];
        hit_tag = hit_tag | cell_tag[i];
      end
    end
  end

  // read at index
  logic [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0] rd_tag;

  always_comb begin
    rd_key = '0;
    rd_tag = '0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      if (32'(i) == 32'(in_i.position)) begin
        rd_key = cell_key[i];
        rd_tag = cell_tag[i];
      end
    end
  end

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rm_d       = rm_q;
    ctrl.op    = CELL_HOLD;
    ctrl.key   = in_i.item_key[KEY_W-1:0];
    ctrl.tag   = in_i.item_tag[TAG_W-1:0];
    shift_vec  = '0;
    load       = 1'b0;
    out_key_d  = '0;
    out_tag_d  = '0;
    out_idx_d  = '0;
    out_stat_d = STAT_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (in_i.func)
            FN_PUSH: begin
              if (count_q == CNT_W'(DEPTH)) begin
                out_stat_d = STAT_FULL;
              end else begin
                ctrl.op = CELL_PUSH;
                count_d = count_q + CNT_W'(1);
              end
            end
            FN_POP, FN_PEEK: begin
              if (count_q == '0) begin
                out_stat_d = STAT_EMPTY;
              end else begin
                out_key_d = cell_key[0];
                out_tag_d = cell_tag[0];
                if (in_i.func == FN_POP) begin
                  ctrl.op   = CELL_SHIFT;
                  shift_vec = '1;
                  count_d   = count_q - CNT_W'(1);
                end
              end
            end
            FN_FIND, FN_REMOVE: begin
              // result comes out of the match cycle
              load    = 1'b0;
              ctrl.op = CELL_MATCH;
              rm_d    = (in_i.func == FN_REMOVE);
              state_d = ST_MATCH;
            end
            FN_READ: begin
              if (32'(in_i.position) >= 32'(count_q)) begin
                out_stat_d = STAT_BAD_INDEX;
              end else begin
                out_key_d = rd_key;
                out_tag_d = rd_tag;
              end
            end
            FN_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      ST_MATCH: begin
        load    = 1'b1;
        state_d = ST_IDLE;
        if (!hit_any) begin
          out_stat_d = STAT_NOT_FOUND;
        end else begin
          out_idx_d = hit_idx;
          if (rm_q) begin
            out_key_d = hit_key;
            out_tag_d = hit_tag;
            ctrl.op   = CELL_SHIFT;
            shift_vec = hit_pre;
            count_d   = count_q - CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rm_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rm_q        <= rm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_key_q  <= out_key_d;
      out_tag_q  <= out_tag_d;
      out_idx_q  <= out_idx_d;
      out_stat_q <= out_stat_d;
      out_occ_q  <= OCC_W'(count_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_key   = 32'(out_key_q);
  assign out_o.out_tag   = 16'(out_tag_q);
  assign out_o.out_index = out_idx_q;
  assign out_o.status    = out_stat_q;
  assign out_o.occupancy = out_occ_q;

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // match cycle only follows an accepted find or remove, with output free
  a_match_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MATCH) |-> !out_valid_q && !in_i.ready)
    else $error("match cycle with busy output or open input");

  // full queue refuses a push and reports it
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func == FN_PUSH && count_q == CNT_W'(DEPTH))
    |=> out_valid_q && out_stat_q == STAT_FULL && count_q == CNT_W'(DEPTH))
    else $error("push on full queue not refused");

  // find or remove yields a result right after the match cycle
  a_match_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MATCH) |=> out_valid_q && state_q == ST_IDLE)
    else $error("match cycle gave no result");

endmodule

// ----- tb/sv/tb_sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps

module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  // func code 7 has no operation behind it; the queue must leave state alone
  localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;

  localparam int unsigned HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 10;      // idle time after the last result
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MIX_ITEMS    = 1400;

  // one queue result as the block reports it
  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [OIDX_W-1:0] index;
    status_e           st;
    logic [OCC_W-1:0]  occ;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  spq_in_if  in_if ();
  spq_out_if out_if ();

  sorted_priority_queue_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow copy of the sorted entries, updated as each item is accepted
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [TAG_W-1:0] shadow_tags [DEPTH];
  int               shadow_count;

  outcome_t    pending_outcomes [$];
  int unsigned error_count;
  int unsigned cycle_count;

  // idling switches; a segment may run with either side flat out
  bit src_idle_en;
  bit snk_idle_en;
  bit hold_req;

  // --------------------------------------------------------------------------
  // clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count > CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // shadow queue: what the block should report for one item
  // --------------------------------------------------------------------------
  function automatic void drop_entry(int at);
    for (int i = at; i + 1 < shadow_count; i++) begin
      shadow_keys[i] = shadow_keys[i + 1];
      shadow_tags[i] = shadow_tags[i + 1];
    end
    shadow_count--;
  endfunction

  function automatic outcome_t sorted_queue_step(logic [FUNC_W-1:0] fn,
                                                 logic [KEY_W-1:0] key_v,
                                                 logic [TAG_W-1:0] tag_v,
                                                 logic [POS_W-1:0] pos_v);
    outcome_t o;
    int       at;
    o.key   = '0;
    o.tag   = '0;
    o.index = '0;
    o.st    = STAT_OK;
    case (fn)
      FN_PUSH: begin
        if (shadow_count >= DEPTH) begin
          o.st = STAT_FULL;
        end else begin
          // goes in front of the first key that is not less: newest equal key first
          at = 0;
          while (at < shadow_count && key_v > shadow_keys[at]) at++;
          for (int i = shadow_count; i > at; i--) begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_tags[i] = shadow_tags[i - 1];
          end
          shadow_keys[at] = key_v;
          shadow_tags[at] = tag_v;
          shadow_count++;
        end
      end
      FN_POP, FN_PEEK: begin
        if (shadow_count == 0) begin
          o.st = STAT_EMPTY;
        end else begin
          o.key = shadow_keys[0];
          o.tag = shadow_tags[0];
          if (fn == FN_POP) drop_entry(0);
        end
      end
      FN_FIND, FN_REMOVE: begin
        at = 0;
        while (at < shadow_count && shadow_tags[at] != tag_v) at++;
        if (at >= shadow_count) begin
          o.st = STAT_NOT_FOUND;
        end else begin
          o.index = at[OIDX_W-1:0];
          if (fn == FN_REMOVE) begin
            o.key = shadow_keys[at];
            o.tag = shadow_tags[at];
            drop_entry(at);
          end
        end
      end
      FN_READ: begin
        if (int'(pos_v) >= shadow_count) begin
          o.st = STAT_BAD_INDEX;
        end else begin
          o.key = shadow_keys[pos_v];
          o.tag = shadow_tags[pos_v];
        end
      end
      FN_CLEAR: shadow_count = 0;
      default: ;
    endcase
    o.occ = shadow_count[OCC_W-1:0];
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // random helpers
  // --------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // narrow ranges give plenty of equal keys to check the tie order
  function automatic logic [KEY_W-1:0] rand_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom();
    if (r < 60) return $urandom_range(0, 15);
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom_range(0, 1000);
  endfunction

  // small tag pool makes duplicates, so find must report the lowest index
  function automatic logic [TAG_W-1:0] rand_tag();
    if ($urandom_range(0, 1) == 0) return TAG_W'($urandom_range(0, 65535));
    return TAG_W'($urandom_range(0, 7));
  endfunction

  // lookups mostly aim at a tag that is stored
  function automatic logic [TAG_W-1:0] lookup_tag();
    if (shadow_count > 0 && $urandom_range(0, 3) != 0)
      return shadow_tags[$urandom_range(0, shadow_count - 1)];
    return rand_tag();
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    if (shadow_count > 0 && $urandom_range(0, 9) < 7)
      return POS_W'($urandom_range(0, shadow_count - 1));
    return POS_W'($urandom_range(0, 63));
  endfunction

  // --------------------------------------------------------------------------
  // sender: offers one item, waits for the handshake, then predicts
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [FUNC_W-1:0] fn,
                           input logic [KEY_W-1:0]  key_v,
                           input logic [TAG_W-1:0]  tag_v,
                           input logic [POS_W-1:0]  pos_v);
    int unsigned gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= fn;
    in_if.item_key <= key_v;
    in_if.item_tag <= tag_v;
    in_if.position <= pos_v;
    // ready sampled at the edge is the pre-edge value, as the block sees it
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pending_outcomes.push_back(sorted_queue_step(fn, key_v, tag_v, pos_v));
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : sink_ctl
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result check: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    error_count++;
  endtask

  initial begin : result_check
    outcome_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with nothing pending, key", out_if.out_key, 0);
        end else begin
          want = pending_outcomes.pop_front();
          if (out_if.out_key !== want.key)
            report_mismatch("out_key", out_if.out_key, want.key);
          if (out_if.out_tag !== want.tag)
            report_mismatch("out_tag", out_if.out_tag, want.tag);
          if (out_if.out_index !== want.index)
            report_mismatch("out_index", out_if.out_index, want.index);
          if (out_if.status !== want.st)
            report_mismatch("status", out_if.status, want.st);
          if (out_if.occupancy !== want.occ)
            report_mismatch("occupancy", out_if.occupancy, want.occ);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // every operation but push on an empty queue
  task automatic test_empty_queue();
    send_item(FN_POP,    '0, '0,         '0);
    send_item(FN_PEEK,   '0, '0,         '0);
    send_item(FN_FIND,   '0, '0,         '0);
    send_item(FN_REMOVE, '0, 16'hFFFF,   '0);
    send_item(FN_READ,   '0, '0,         6'd0);
    send_item(FN_READ,   '0, '0,         6'd63);
    send_item(FN_CLEAR,  '0, '0,         '0);
    send_item(FN_SPARE,  '1, 16'hFFFF,   6'd63);
  endtask

  // key extremes, tie order, duplicate tags, lookups that miss
  task automatic test_order_and_lookup();
    send_item(FN_PUSH,   32'hFFFF_FFFF, 16'h0001, '0);
    send_item(FN_PUSH,   32'h0000_0000, 16'hFFFF, '0);
    send_item(FN_PUSH,   32'd5,         16'h0000, '0);
    send_item(FN_PUSH,   32'd5,         16'h0002, '0);  // lands ahead of the older 5
    send_item(FN_PUSH,   32'h8000_0000, 16'h0001, '0);  // second entry with tag 1
    send_item(FN_PEEK,   '0, '0, '0);
    send_item(FN_READ,   '0, '0, 6'd1);
    send_item(FN_READ,   '0, '0, 6'd4);
    send_item(FN_READ,   '0, '0, 6'd5);                 // one past the last entry
    send_item(FN_FIND,   '0, 16'h0001, '0);
    send_item(FN_REMOVE, '0, 16'h0001, '0);
    send_item(FN_FIND,   '0, 16'h0001, '0);
    send_item(FN_REMOVE, '0, 16'h1234, '0);             // miss leaves queue intact
    send_item(FN_FIND,   '0, 16'h1234, '0);
    send_item(FN_POP,    '0, '0, '0);
    send_item(FN_SPARE,  32'hA5A5_A5A5, 16'h5A5A, 6'd42);
    send_item(FN_CLEAR,  '0, '0, '0);
  endtask

  // receiver holds off long while items keep coming; input must stall
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_req    = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_item(FN_READ, '0, '0, rand_pos());
      else            send_item(FN_PUSH, rand_key(), rand_tag(), '0);
    end
    src_idle_en = 1'b1;
  endtask

  // fill to the top, push into a full queue, then drain by pop and remove, or by clear
  task automatic test_fill_and_drain();
    for (int round = 0; round < 2; round++) begin
      while (shadow_count < DEPTH) send_item(FN_PUSH, rand_key(), rand_tag(), '0);
      repeat (3) send_item(FN_PUSH, rand_key(), rand_tag(), '0);
      send_item(FN_READ, '0, '0, 6'd63);
      send_item(FN_FIND, '0, lookup_tag(), '0);
      if (round == 0) begin
        while (shadow_count > 0) begin
          if ($urandom_range(0, 4) == 0) send_item(FN_REMOVE, '0, lookup_tag(), '0);
          else                           send_item(FN_POP, '0, '0, '0);
        end
        repeat (2) send_item(FN_POP, '0, '0, '0);
      end else begin
        send_item(FN_CLEAR, '0, '0, '0);
        send_item(FN_PEEK, '0, '0, '0);
      end
    end
  endtask

  // segments with fill, drain or balanced op mixes and varying idling
  task automatic test_random_mix();
    int unsigned push_pct;
    int unsigned r;
    logic [FUNC_W-1:0] fn;
    for (int seg = 0; seg < MIX_ITEMS / 100; seg++) begin
      case ($urandom_range(0, 2))
        0: push_pct = 70;
        1: push_pct = 25;
        default: push_pct = 45;
      endcase
      src_idle_en = ($urandom_range(0, 4) != 0);
      snk_idle_en = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          fn = FN_PUSH;
        end else begin
          r = $urandom_range(0, 99);
          if      (r < 30) fn = FN_POP;
          else if (r < 42) fn = FN_PEEK;
          else if (r < 57) fn = FN_FIND;
          else if (r < 75) fn = FN_REMOVE;
          else if (r < 96) fn = FN_READ;
          else if (r < 97) fn = FN_CLEAR;
          else             fn = FN_SPARE;
        end
        // unused fields carry random bits; the block must ignore them
        if (fn == FN_FIND || fn == FN_REMOVE)
          send_item(fn, $urandom(), lookup_tag(), POS_W'($urandom_range(0, 63)));
        else if (fn == FN_READ)
          send_item(fn, $urandom(), TAG_W'($urandom_range(0, 65535)), rand_pos());
        else
          send_item(fn, rand_key(), rand_tag(), POS_W'($urandom_range(0, 63)));
      end
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.func     <= FN_PUSH;
    in_if.item_key <= '0;
    in_if.item_tag <= '0;
    in_if.position <= '0;
    shadow_count = 0;
    error_count  = 0;
    src_idle_en  = 1'b1;
    snk_idle_en  = 1'b1;
    hold_req     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_order_and_lookup();
    test_backpressure();
    test_fill_and_drain();
    test_random_mix();

    in_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
